### sv/csfw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package csfw_pkg;

	localparam int QUEUE_DEPTH_DEF = 8;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int TASK_W    = 3;
	localparam int INIT_W    = 16;
	localparam int COUNT_O_W = 16;
	localparam int WAITERS_W = 4;

	typedef enum logic [1:0] {
		ACT_WAIT = 2'd0,
		ACT_TRY  = 2'd1,
		ACT_POST = 2'd2,
		ACT_NONE = 2'd3
	} action_t;

	typedef struct packed {
		action_t           action;
		logic [TASK_W-1:0] task_id;
	} req_t;

	typedef struct packed {
		logic                 granted;
		logic                 blocked;
		logic                 woke_valid;
		logic [TASK_W-1:0]    woke_task;
		logic [COUNT_O_W-1:0] count_now;
		logic [WAITERS_W-1:0] waiters_now;
		logic                 overflow;
	} rsp_t;

	// Control for the row of queue cells.
	typedef struct packed {
		logic              push;
		logic              pop;
		logic [TASK_W-1:0] push_task;
	} chain_ctl_t;

endpackage

`default_nettype wire

### sv/csfw_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module csfw_cell (
	input  wire logic                        clk,
	input  wire logic                        load,
	input  wire logic                        shift,
	input  wire logic [csfw_pkg::TASK_W-1:0] load_task,
	input  wire logic [csfw_pkg::TASK_W-1:0] next_task,
	output logic      [csfw_pkg::TASK_W-1:0] task_q
);

	always_ff @(posedge clk) begin
		if (load) begin
			task_q <= load_task;
		end else if (shift) begin
			task_q <= next_task;
		end
	end

endmodule

`default_nettype wire

### sv/csfw_chain.sv
`timescale 1ns / 1ps
`default_nettype none

module csfw_chain #(
	parameter int QUEUE_DEPTH = csfw_pkg::QUEUE_DEPTH_DEF,
	localparam int WW = $clog2(QUEUE_DEPTH + 1)
) (
	input  wire logic                        clk,
	input  wire csfw_pkg::chain_ctl_t        ctl,
	input  wire logic [WW-1:0]               tail,
	output logic      [csfw_pkg::TASK_W-1:0] head_task
);

	logic [csfw_pkg::TASK_W-1:0] task_q [QUEUE_DEPTH];

	// The oldest waiter sits in cell 0; a pop moves every cell one place
	// toward the head, and a push writes the first free cell.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [csfw_pkg::TASK_W-1:0] nxt;
		if (i == QUEUE_DEPTH - 1) begin : g_last
			assign nxt = task_q[i];
		end else begin : g_mid
			assign nxt = task_q[i+1];
		end
		csfw_cell u_cell (
			.clk       (clk),
			.load      (ctl.push && (tail == WW'(i))),
			.shift     (ctl.pop),
			.load_task (ctl.push_task),
			.next_task (nxt),
			.task_q    (task_q[i])
		);
	end

	assign head_task = task_q[0];

endmodule

`default_nettype wire

### sv/counting_semaphore_fifo_waiters_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Counting semaphore with a first-in first-out queue of waiting tasks.
// Request channel (req_valid, req_stall, req): a word carries an action
// (wait, try-wait, post) and a task number. Response channel (rsp_valid,
// rsp_stall, rsp): one word per request with the grant, block and wake
// flags, the woken task, the count and waiter total after the request,
// and an overflow flag for a full queue or a saturated count.
// The response is registered and shows in the cycle after its request is
// taken. Throughput is one request per cycle unless req_stall is high;
// the count and the queue update in the same cycle, and the queue is a
// row of cells that shifts toward the head on every wake.
// While the receiver stalls, the response register holds and req_stall
// is raised, so no request is lost.
// Reset clears the count and the waiter total; queue cells are not
// cleared and are read only while occupied. A write on the cfg channel
// loads the count from cfg_data and empties the queue; it is meant only
// while the block is idle.
module counting_semaphore_fifo_waiters_top #(
	parameter int QUEUE_DEPTH = csfw_pkg::QUEUE_DEPTH_DEF,
	parameter int COUNT_WIDTH = csfw_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire csfw_pkg::req_t              req,
	output logic                             rsp_valid,
	input  wire logic                        rsp_stall,
	output csfw_pkg::rsp_t                   rsp,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [csfw_pkg::INIT_W-1:0] cfg_data
);

	localparam int WW = $clog2(QUEUE_DEPTH + 1);

	logic [COUNT_WIDTH-1:0]      count_q, count_nxt;
	logic [WW-1:0]               total_q, total_nxt;
	logic                        rsp_valid_q;
	csfw_pkg::rsp_t              rsp_q, rsp_nxt;
	csfw_pkg::chain_ctl_t        ctl;
	logic [csfw_pkg::TASK_W-1:0] head_task;
	logic                        accept;
	logic                        is_wait, is_try, is_post;
	logic                        cnt_zero, cnt_max, q_full, q_empty;
	logic                        take, block, wake, inc, ovf;
	logic [COUNT_WIDTH+csfw_pkg::INIT_W-1:0]    init_ext;
	logic [COUNT_WIDTH+csfw_pkg::COUNT_O_W-1:0] cnt_ext;
	logic [WW+csfw_pkg::WAITERS_W-1:0]          tot_ext;

	assign cfg_ready = 1'b1;
	assign req_stall = rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;

	assign is_wait = (req.action == csfw_pkg::ACT_WAIT);
	assign is_try  = (req.action == csfw_pkg::ACT_TRY);
	assign is_post = (req.action == csfw_pkg::ACT_POST);

	assign cnt_zero = (count_q == '0);
	assign cnt_max  = &count_q;
	assign q_full   = (total_q == WW'(QUEUE_DEPTH));
	assign q_empty  = (total_q == '0);

	assign take  = (is_wait || is_try) && !cnt_zero;
	assign block = is_wait && cnt_zero && !q_full;
	assign wake  = is_post && !q_empty;
	assign inc   = is_post && q_empty && !cnt_max;
	assign ovf   = (is_wait && cnt_zero && q_full) || (is_post && q_empty && cnt_max);

	always_comb begin
		count_nxt = count_q;
		if (take) begin
			count_nxt = count_q - COUNT_WIDTH'(1);
		end else if (inc) begin
			count_nxt = count_q + COUNT_WIDTH'(1);
		end
		total_nxt = total_q;
		if (block) begin
			total_nxt = total_q + WW'(1);
		end else if (wake) begin
			total_nxt = total_q - WW'(1);
		end
	end

	assign cnt_ext  = {{csfw_pkg::COUNT_O_W{1'b0}}, count_nxt};
	assign tot_ext  = {{csfw_pkg::WAITERS_W{1'b0}}, total_nxt};
	assign init_ext = {{COUNT_WIDTH{1'b0}}, cfg_data};

	always_comb begin
		rsp_nxt.granted     = take;
		rsp_nxt.blocked     = block;
		rsp_nxt.woke_valid  = wake;
		rsp_nxt.woke_task   = wake ? head_task : '0;
		rsp_nxt.count_now   = cnt_ext[csfw_pkg::COUNT_O_W-1:0];
		rsp_nxt.waiters_now = tot_ext[csfw_pkg::WAITERS_W-1:0];
		rsp_nxt.overflow    = ovf;
	end

	assign ctl.push      = accept && block;
	assign ctl.pop       = accept && wake;
	assign ctl.push_task = req.task_id;

	csfw_chain #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_chain (
		.clk       (clk),
		.ctl       (ctl),
		.tail      (total_q),
		.head_task (head_task)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				count_q <= init_ext[COUNT_WIDTH-1:0];
				total_q <= '0;
			end else if (accept) begin
				count_q <= count_nxt;
				total_q <= total_nxt;
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

### sv/csfw_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module csfw_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire csfw_pkg::rsp_t rsp
);

	// A held response blocks new requests.
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request taken while response held");

	// Every accepted request produces a response in the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("response missing after accepted request");

	// A request ends in at most one outcome.
	a_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $onehot0({rsp.granted, rsp.blocked, rsp.woke_valid, rsp.overflow}))
		else $error("more than one outcome flag");

	// The woken task number is zero unless a task was woken.
	a_woke: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.woke_valid |-> rsp.woke_task == '0)
		else $error("woken task without wake");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

endmodule

bind counting_semaphore_fifo_waiters_top csfw_checker u_csfw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

`default_nettype wire
